// ----- design/bsmg_pkg.sv -----
// ----------------------------------------------------------------------------
// bsmg_pkg
// Shared types, constants and helpers for the bounded set min/max gap unit.
// ----------------------------------------------------------------------------
package bsmg_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned CAP_W    = 7;
   localparam int unsigned COUNT_OW = 7;
   localparam int unsigned MIN_SPAN_COUNT = 2;

   localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

   // Register index of the capacity register
   localparam logic REG_CAPACITY = 1'b0;

   // Link handed from one cell to the next one up the chain
   typedef struct packed {
      logic              ge;     // cell holds a number <= the incoming word
      logic [DATA_W-1:0] value;  // number held by the cell
   } cell_link_type;

   // Signed order of two 32-bit words
   function automatic logic below_f(input logic [DATA_W-1:0] a,
                                    input logic [DATA_W-1:0] b);
      return $signed(a) < $signed(b);
   endfunction

endpackage

// ----- design/bounded_set_min_max_gap_unit.sv -----
// ----------------------------------------------------------------------------
// bounded_set_min_max_gap_unit
// Bounded sorted set of signed numbers reporting minimum neighbor gap and
// total range after every word.
// ----------------------------------------------------------------------------
// Each input word goes through the accept state, a scan of the cell chain
// (all cells compare against the word at once and shift-insert it in the
// same edge) and a finish state that folds the two new neighbor gaps into
// the running minimum and updates the range. One word is in flight at a
// time; the result sits in an output register, and the next word is
// accepted while it waits. The finish state stalls only while the previous
// result has not been taken. The set holds at most min(capacity, DEPTH)
// numbers; a word arriving when full is dropped and flagged in rsp_tuser,
// and a restart flag empties the set first.
// ----------------------------------------------------------------------------
module bounded_set_min_max_gap_unit
   import bsmg_pkg::*;
#(
   parameter int unsigned DEPTH = 64
)
(
   input  logic         clock,
   input  logic         reset,
   // input words
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] value
   input  logic         req_tuser,   // [0] restart
   // result words
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,   // [6:0] count, [7] spans_valid,
                                     // [39:8] shortest_span, [71:40] longest_span
   output logic         rsp_tuser,   // [0] status
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int unsigned CW = $clog2(DEPTH+1);
   localparam int unsigned WW = (CW > CAP_W) ? CW : CAP_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CAP_W-1:0]  capacity_ff, capacity_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic              drop_ff, drop_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [DATA_W-1:0] min_gap_ff, min_gap_in;
   logic [DATA_W-1:0] small_ff, small_in;
   logic [DATA_W-1:0] large_ff, large_in;
   logic [DATA_W-1:0] pred_ff, pred_in;
   logic [DATA_W-1:0] succ_ff, succ_in;
   logic              has_pred_ff, has_pred_in;
   logic              has_succ_ff, has_succ_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [71:0]       rsp_tdata_ff, rsp_tdata_in;
   logic              rsp_tuser_ff, rsp_tuser_in;

   logic              req_fire;
   logic              cfg_write;
   logic              commit;
   logic [CW-1:0]     start_count;
   logic              full;
   logic [DATA_W-1:0] chain_pred;
   logic [DATA_W-1:0] chain_succ;
   logic              chain_has_pred;
   logic              chain_has_succ;
   logic [DATA_W-1:0] gap_lo;
   logic [DATA_W-1:0] gap_hi;
   logic [DATA_W-1:0] gap_min;
   logic              spans_valid;
   logic [DATA_W-1:0] shortest;
   logic [DATA_W-1:0] longest;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_CAPACITY);
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ?
                       {{(32-CAP_W){1'b0}}, capacity_ff} : '0;
   assign capacity_in = cfg_write ? csr_pwdata[CAP_W-1:0] : capacity_ff;

   // fullness against the clamped capacity
   assign start_count = req_tuser ? '0 : count_ff;
   assign full = (WW'(start_count) >= WW'(capacity_ff)) ||
                 (start_count == CW'(DEPTH));

   bsmg_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock      (clock),
      .word_value (val_ff),
      .insert     ((state_ff == S_SCAN) && !drop_ff),
      .count      (count_ff),
      .pred_value (chain_pred),
      .succ_value (chain_succ),
      .has_pred   (chain_has_pred),
      .has_succ   (chain_has_succ)
   );

   assign commit = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);

   assign gap_lo = val_ff - pred_ff;
   assign gap_hi = succ_ff - val_ff;

   always_comb begin
      gap_min = min_gap_ff;
      if (has_pred_ff && (gap_lo < gap_min)) begin
         gap_min = gap_lo;
      end
      if (has_succ_ff && (gap_hi < gap_min)) begin
         gap_min = gap_hi;
      end
   end

   always_comb begin
      state_in      = state_ff;
      val_in        = val_ff;
      drop_in       = drop_ff;
      count_in      = count_ff;
      min_gap_in    = min_gap_ff;
      small_in      = small_ff;
      large_in      = large_ff;
      pred_in       = pred_ff;
      succ_in       = succ_ff;
      has_pred_in   = has_pred_ff;
      has_succ_in   = has_succ_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      spans_valid   = 1'b0;
      shortest      = '0;
      longest       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               val_in  = req_tdata;
               drop_in = full;
               if (req_tuser) begin
                  // empty the set before this word goes in
                  count_in   = '0;
                  min_gap_in = ALL_ONES;
                  small_in   = '0;
                  large_in   = '0;
               end
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // latch the neighbors while the chain shifts the word in
            pred_in     = chain_pred;
            succ_in     = chain_succ;
            has_pred_in = chain_has_pred;
            has_succ_in = chain_has_succ;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!drop_ff) begin
               count_in   = count_ff + 1'b1;
               min_gap_in = gap_min;
               if (count_ff == '0) begin
                  small_in = val_ff;
                  large_in = val_ff;
               end else begin
                  if (below_f(val_ff, small_ff)) small_in = val_ff;
                  if (below_f(large_ff, val_ff)) large_in = val_ff;
               end
            end
            spans_valid = WW'(count_in) >= WW'(MIN_SPAN_COUNT);
            shortest    = spans_valid ? min_gap_in : '0;
            longest     = spans_valid ? (large_in - small_in) : '0;
            if (commit) begin
               rsp_tvalid_in = 1'b1;
               rsp_tuser_in  = drop_ff;
               rsp_tdata_in  = {longest, shortest, spans_valid, COUNT_OW'(count_in)};
               state_in      = S_IDLE;
            end else begin
               // hold until the result register frees up
               count_in   = count_ff;
               min_gap_in = min_gap_ff;
               small_in   = small_ff;
               large_in   = large_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         capacity_ff   <= CAP_W'(64);
         count_ff      <= '0;
         min_gap_ff    <= ALL_ONES;
         small_ff      <= '0;
         large_ff      <= '0;
         drop_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         capacity_ff   <= capacity_in;
         count_ff      <= count_in;
         min_gap_ff    <= min_gap_in;
         small_ff      <= small_in;
         large_ff      <= large_in;
         drop_ff       <= drop_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      pred_ff      <= pred_in;
      succ_ff      <= succ_in;
      has_pred_ff  <= has_pred_in;
      has_succ_ff  <= has_succ_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond chain depth");

   a_accept_to_scan : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_SCAN))
      else $error("accepted word did not start a scan");

   a_invalid_spans_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tdata_ff[7]) |->
         ((rsp_tdata_ff[39:8] == '0) && (rsp_tdata_ff[71:40] == '0)))
      else $error("spans reported without two entries");

   a_drop_keeps_count : assert property (@(posedge clock) disable iff (reset)
      (commit && drop_ff) |=> (count_ff == $past(count_ff)))
      else $error("dropped word changed the entry count");

endmodule

// ----- design/bsmg_cell.sv -----
// ----------------------------------------------------------------------------
// bsmg_cell
// One slot of the sorted chain: holds a number, compares it with the
// incoming word and takes either the word or its lower neighbor's number.
// ----------------------------------------------------------------------------
module bsmg_cell
   import bsmg_pkg::*;
(
   input  logic                 clock,
   input  logic [DATA_W-1:0]    word_value,
   input  logic                 insert,
   input  logic                 occupied,
   input  cell_link_type        prev_link,
   input  logic                 next_ge,
   output cell_link_type        link,
   output logic                 pred_hit,
   output logic                 succ_hit,
   output logic [DATA_W-1:0]    pred_term,
   output logic [DATA_W-1:0]    succ_term
);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              ge;

   assign ge = occupied && !below_f(word_value, value_ff);

   assign link.ge    = ge;
   assign link.value = value_ff;

   // last number not above the word, and first number above it
   assign pred_hit  = ge && !next_ge;
   assign succ_hit  = occupied && !ge && prev_link.ge;
   assign pred_term = pred_hit ? value_ff : '0;
   assign succ_term = succ_hit ? value_ff : '0;

   always_comb begin
      value_in = value_ff;
      if (insert && !ge) begin
         // the insertion point takes the word, everything above shifts up
         value_in = prev_link.ge ? word_value : prev_link.value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

// ----- design/bsmg_chain.sv -----
// ----------------------------------------------------------------------------
// bsmg_chain
// Row of sorted cells with the neighbor pick-off for the inserted word.
// ----------------------------------------------------------------------------
module bsmg_chain
   import bsmg_pkg::*;
#(
   parameter int unsigned DEPTH = 64
)
(
   input  logic                         clock,
   input  logic [DATA_W-1:0]            word_value,
   input  logic                         insert,
   input  logic [$clog2(DEPTH+1)-1:0]   count,
   output logic [DATA_W-1:0]            pred_value,
   output logic [DATA_W-1:0]            succ_value,
   output logic                         has_pred,
   output logic                         has_succ
);

   localparam int unsigned CW = $clog2(DEPTH+1);

   cell_link_type     links [DEPTH];
   logic              pred_hit  [DEPTH];
   logic              succ_hit  [DEPTH];
   logic [DATA_W-1:0] pred_term [DEPTH];
   logic [DATA_W-1:0] succ_term [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_link_type prev_link;
      logic          next_ge;
      logic          occupied;

      assign occupied = count > CW'(i);

      if (i == 0) begin : g_first
         // below the first cell sits a virtual entry that is always <= word
         assign prev_link.ge    = 1'b1;
         assign prev_link.value = '0;
      end else begin : g_inner
         assign prev_link = links[i-1];
      end

      if (i == DEPTH-1) begin : g_last
         assign next_ge = 1'b0;
      end else begin : g_body
         assign next_ge = links[i+1].ge;
      end

      bsmg_cell u_cell (
         .clock      (clock),
         .word_value (word_value),
         .insert     (insert),
         .occupied   (occupied),
         .prev_link  (prev_link),
         .next_ge    (next_ge),
         .link       (links[i]),
         .pred_hit   (pred_hit[i]),
         .succ_hit   (succ_hit[i]),
         .pred_term  (pred_term[i]),
         .succ_term  (succ_term[i])
      );
   end

   // at most one cell hits on each side
   always_comb begin
      pred_value = '0;
      succ_value = '0;
      has_pred   = 1'b0;
      has_succ   = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         pred_value = pred_value | pred_term[i];
         succ_value = succ_value | succ_term[i];
         has_pred   = has_pred | pred_hit[i];
         has_succ   = has_succ | succ_hit[i];
      end
   end

endmodule
